// ----- design/bfsa_pkg.sv -----
package bfsa_pkg;

    // Pool geometry
    localparam int SLOTS       = 256;
    localparam int CAP_W       = 32;
    localparam int SLOT_BITS   = 8;
    localparam int AMOUNT_BITS = 32;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = (IDX_W > SLOT_BITS) ? IDX_W : SLOT_BITS;
    localparam int CMP_W  = (CAP_W > AMOUNT_BITS) ? CAP_W : AMOUNT_BITS;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]             command;
        logic [SLOT_BITS-1:0]   slot;
        logic [AMOUNT_BITS-1:0] amount;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] granted_slot;
    } rsp_t;

    // Running best candidate passed down the cell row
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [CAP_W-1:0] cap;
    } cand_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                   load;
        logic                   rel;
        logic [SLOT_BITS-1:0]   slot;
        logic [CAP_W-1:0]       wr_cap;
        logic [AMOUNT_BITS-1:0] req_amount;
        logic                   take;
        logic [IDX_W-1:0]       take_idx;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ----- design/bfsa_cell.sv -----
module bfsa_cell
    import bfsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] index,
    input  cell_ctl_t        ctl,
    input  cand_t            cand_in,
    output cand_t            cand_out
);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             free_reg, free_next;
    logic             loaded_reg, loaded_next;
    cand_t            cand_reg, cand_next;

    logic addr_hit;
    logic fits;

    assign addr_hit = (ADDR_W'(ctl.slot) == ADDR_W'(index));

    // Slot state update: load, release, grant
    always_comb
    begin
        cap_next    = cap_reg;
        free_next   = free_reg;
        loaded_next = loaded_reg;
        if (ctl.load && addr_hit)
        begin
            cap_next    = ctl.wr_cap;
            free_next   = 1'b1;
            loaded_next = 1'b1;
        end
        else if (ctl.rel && addr_hit && loaded_reg)
        begin
            free_next = 1'b1;
        end
        else if (ctl.take && ctl.take_idx == index)
        begin
            free_next = 1'b0;
        end
    end

    // Best-fit compare against the candidate from the left neighbor
    assign fits = free_reg && (CMP_W'(cap_reg) >= CMP_W'(ctl.req_amount));

    always_comb
    begin
        cand_next = cand_in;
        if (fits && (!cand_in.hit || cap_reg < cand_in.cap))
        begin
            cand_next.hit = 1'b1;
            cand_next.idx = index;
            cand_next.cap = cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg   <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            free_reg   <= free_next;
            loaded_reg <= loaded_next;
        end
    end

    // Payload: capacity and passing candidate
    always_ff @(posedge clk)
    begin
        cap_reg  <= cap_next;
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

// ----- design/best_fit_slot_allocator.sv -----
// Load and release beats give no result.
// An allocate beat walks a row of SLOTS cells, one cell per cycle; its result
// is registered once the scan counter reaches SLOTS and the output register is
// free, and no new beat is taken until then, so allocates never overlap.
// Reset (rst_n, async, active low) marks every slot unloaded and taken and
// clears the output valid flag; capacities are undefined until loaded.
module best_fit_slot_allocator
    import bfsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [AMOUNT_BITS-1:0] amt_reg, amt_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg, out_next;

    logic      in_fire;
    logic      scan_done;
    logic      finish;
    cell_ctl_t ctl;
    cand_t     chain [SLOTS+1];
    cand_t     best;

    assign in_fire   = in_valid && in_ready;
    assign scan_done = (cnt_reg == CNT_W'(SLOTS));
    assign best      = chain[SLOTS];
    assign finish    = (state_reg == ST_SCAN) && scan_done && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        amt_next       = amt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.command == CMD_ALLOC)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    amt_next   = in_data.amount;
                end
            end
            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (finish)
                begin
                    state_next         = ST_IDLE;
                    out_valid_next     = 1'b1;
                    out_next.found     = best.hit;
                    out_next.granted_slot = best.hit ? SLOT_BITS'(best.idx) : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Broadcast control to the cell row
    always_comb
    begin
        ctl.load       = in_fire && (in_data.command == CMD_LOAD);
        ctl.rel        = in_fire && (in_data.command == CMD_RELEASE);
        ctl.slot       = in_data.slot;
        ctl.wr_cap     = CAP_W'(in_data.amount);
        ctl.req_amount = amt_reg;
        ctl.take       = finish && best.hit;
        ctl.take_idx   = best.idx;
    end

    // Cell row: empty candidate enters at the left end
    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        bfsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (IDX_W'(i)),
            .ctl      (ctl),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg <= amt_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_alloc_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.command == CMD_ALLOC) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("allocate did not start a scan");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("scan counter overran the cell row");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.granted_slot == '0))
        else $error("not-found result carries a slot number");

    a_grant_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(state_reg) == ST_SCAN && $past(scan_done)))
        else $error("result presented before the scan finished");

endmodule
